// File: hw/rtl/cnv3_pkg.sv
package cnv3_pkg;

  localparam int MaxWidth = 2048;
  localparam int CoefBits = 8;
  localparam int AddrBits = $clog2(MaxWidth);
  localparam int PixBits = 24;
  localparam int SumBits = 20;
  localparam int DivBits = 10;
  localparam int QuoBits = SumBits;

  typedef logic [PixBits-1:0] pix_t;
  typedef logic [2*PixBits-1:0] line_t;

  typedef enum logic [2:0] {
    RegKernelTop    = 3'd0,
    RegKernelMid    = 3'd1,
    RegKernelBottom = 3'd2,
    RegDivisor      = 3'd3,
    RegWidth        = 3'd4,
    RegHeight       = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [10:0] col;
    logic        last;
  } res_t;

  typedef struct packed {
    logic signed [SumBits-1:0] red;
    logic signed [SumBits-1:0] green;
    logic signed [SumBits-1:0] blue;
    logic [11:0]               row;
    logic [10:0]               col;
    logic                      last;
  } sums_t;

endpackage

// File: hw/rtl/conv3x3_rgb_divide_clamp.sv
// sequence: read, mac and a 20-step divide lie between the input transfer and the result
// occupancy: one pixel at a time; the input is held off while the bit-serial divider
// runs, and a stalled result holds the input off until its transfer
// border pixels pass only read and mac and give no result
// reset: counters and window cleared, registers to defaults, line store undefined
module conv3x3_rgb_divide_clamp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic [11:0] out_row_o,
  output logic [10:0] out_col_o,
  output logic        frame_last_o
);
  import cnv3_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StRead, StMac, StDiv, StOut
  } state_e;

  state_e state_q;
  logic [23:0] k_q [3];
  logic [9:0]  div_q;
  logic [11:0] width_q;
  logic [12:0] height_q;
  logic [11:0] row_q;
  logic [11:0] col_q;
  pix_t        win_q [3][2];
  pix_t        px_q;
  res_t        res_q;
  logic        emit_q;
  sums_t       sums_q;

  logic [11:0] w_eff, col_a;
  logic [12:0] h_eff;
  logic [12:0] row_a;
  logic [AddrBits-1:0] addr;
  line_t rd;
  pix_t  cn [3];
  logic  start, done;
  res_t  dres;
  logic signed [SumBits-1:0] acc [3];

  assign w_eff = (width_q < 12'd3) ? 12'd3 : (width_q > 12'd2048 ? 12'd2048 : width_q);
  assign h_eff = (height_q < 13'd3) ? 13'd3 : (height_q > 13'd4096 ? 13'd4096 : height_q);

  always_comb begin
    col_a = col_q;
    row_a = {1'b0, row_q};
    if (col_q >= w_eff) begin
      col_a = '0;
      row_a = row_a + 13'd1;
    end
    if (row_a >= h_eff) row_a = '0;
  end

  assign addr = col_a[AddrBits-1:0];

  cnv3_line_ram #(.Depth(MaxWidth), .Width(2*PixBits)) u_ram (
    .clk_i  (clk_i),
    .we_i   (state_q == StMac),
    .waddr_i(addr),
    .wdata_i({rd[PixBits-1:0], px_q}),
    .re_i   (state_q == StRead),
    .raddr_i(addr),
    .rdata_o(rd)
  );

  assign cn[0] = rd[2*PixBits-1:PixBits];
  assign cn[1] = rd[PixBits-1:0];
  assign cn[2] = px_q;

  always_comb begin
    logic signed [CoefBits-1:0] cf;
    logic [7:0] p;
    logic signed [CoefBits+8:0] prod;
    for (int c = 0; c < 3; c++) acc[c] = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        cf = k_q[r][k*CoefBits +: CoefBits];
        for (int c = 0; c < 3; c++) begin
          p = (k < 2) ? win_q[r][k][8*c +: 8] : cn[r][8*c +: 8];
          prod = $signed({1'b0, p}) * cf;
          acc[c] = acc[c] + SumBits'(prod);
        end
      end
    end
  end

  assign start = (state_q == StMac) && (row_a >= 13'd2) && (col_a >= 12'd2);

  cnv3_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == StDiv && emit_q),
    .sums_i (sums_q),
    .div_i  (div_q),
    .done_o (done),
    .res_o  (dres)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign red_out_o    = res_q.red;
  assign green_out_o  = res_q.green;
  assign blue_out_o   = res_q.blue;
  assign out_row_o    = res_q.row;
  assign out_col_o    = res_q.col;
  assign frame_last_o = res_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      k_q[0]   <= 24'h0;
      k_q[1]   <= 24'h010000;
      k_q[2]   <= 24'h0;
      div_q    <= 10'd1;
      width_q  <= 12'd640;
      height_q <= 13'd480;
      row_q    <= '0;
      col_q    <= '0;
      emit_q   <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= '0;
        win_q[r][1] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegKernelTop:    k_q[0] <= cfg_data_i;
          RegKernelMid:    k_q[1] <= cfg_data_i;
          RegKernelBottom: k_q[2] <= cfg_data_i;
          RegDivisor:      div_q <= cfg_data_i[9:0];
          RegWidth:        width_q <= cfg_data_i[11:0];
          RegHeight:       height_q <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            px_q    <= {blue_in_i, green_in_i, red_in_i};
            state_q <= StRead;
          end
        end
        StRead: state_q <= StMac;
        StMac: begin
          emit_q <= start;
          sums_q.red   <= acc[0];
          sums_q.green <= acc[1];
          sums_q.blue  <= acc[2];
          sums_q.row   <= 12'(row_a - 13'd1);
          sums_q.col   <= 11'(col_a - 12'd1);
          sums_q.last  <= (row_a == h_eff - 13'd1) && (col_a == w_eff - 12'd1);
          for (int r = 0; r < 3; r++) begin
            win_q[r][0] <= win_q[r][1];
            win_q[r][1] <= cn[r];
          end
          if (col_a + 12'd1 >= w_eff) begin
            col_q <= '0;
            row_q <= (row_a + 13'd1 >= h_eff) ? 12'd0 : 12'(row_a + 13'd1);
          end else begin
            col_q <= col_a + 12'd1;
            row_q <= row_a[11:0];
          end
          state_q <= start ? StDiv : StIdle;
        end
        StDiv: begin
          emit_q <= 1'b0;
          if (done) begin
            res_q   <= dres;
            state_q <= StOut;
          end
        end
        StOut: if (!out_stall_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// File: hw/rtl/cnv3_line_ram.sv
module cnv3_line_ram #(
  parameter int Depth = 2048,
  parameter int Width = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem[raddr_i];
  end
endmodule

// File: hw/rtl/cnv3_divider.sv
module cnv3_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  cnv3_pkg::sums_t       sums_i,
  input  logic [9:0]            div_i,
  output logic                  done_o,
  output cnv3_pkg::res_t        res_o
);
  import cnv3_pkg::*;

  localparam int CntBits = $clog2(QuoBits + 1);

  logic [QuoBits-1:0] num_q [3];
  logic [DivBits:0]   rem_q [3];
  logic [2:0]         neg_q;
  logic [DivBits-1:0] dv_q;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q;
  logic [11:0]        row_q;
  logic [10:0]        col_q;
  logic               last_q;
  logic [7:0]         ch_o [3];

  logic signed [SumBits-1:0] sv [3];
  logic [DivBits+1:0] trial [3];
  logic [DivBits:0]   rsh [3];

  always_comb begin
    sv[0] = sums_i.red;
    sv[1] = sums_i.green;
    sv[2] = sums_i.blue;
    for (int c = 0; c < 3; c++) begin
      rsh[c] = {rem_q[c][DivBits-1:0], num_q[c][QuoBits-1]};
      trial[c] = {1'b0, rsh[c]} - {2'b00, dv_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(QuoBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int c = 0; c < 3; c++) begin
        neg_q[c] <= sv[c][SumBits-1];
        num_q[c] <= sv[c][SumBits-1] ? QuoBits'(-sv[c]) : QuoBits'(sv[c]);
        rem_q[c] <= '0;
      end
      dv_q   <= (div_i == '0) ? DivBits'(1) : div_i;
      row_q  <= sums_i.row;
      col_q  <= sums_i.col;
      last_q <= sums_i.last;
    end else if (busy_q) begin
      for (int c = 0; c < 3; c++) begin
        if (!trial[c][DivBits+1]) begin
          rem_q[c] <= trial[c][DivBits:0];
          num_q[c] <= {num_q[c][QuoBits-2:0], 1'b1};
        end else begin
          rem_q[c] <= rsh[c];
          num_q[c] <= {num_q[c][QuoBits-2:0], 1'b0};
        end
      end
    end
  end

  // negative quotients clamp to zero, quotients above 255 clamp to 255
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (neg_q[c]) ch_o[c] = 8'd0;
      else if (num_q[c] > QuoBits'(255)) ch_o[c] = 8'd255;
      else ch_o[c] = num_q[c][7:0];
    end
    res_o.red   = ch_o[0];
    res_o.green = ch_o[1];
    res_o.blue  = ch_o[2];
    res_o.row   = row_q;
    res_o.col   = col_q;
    res_o.last  = last_q;
  end
endmodule

// File: hw/rtl/cnv3_checker.sv
module cnv3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  red_out_o,
  input logic [11:0] out_row_o,
  input logic [10:0] out_col_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_out_o))
    else $error("result changed while stalled");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");
  a_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_row_o != 12'd0 && out_col_o != 11'd0)
    else $error("border position reported");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transfer without gap");
endmodule

bind conv3x3_rgb_divide_clamp cnv3_checker u_chk (.*);
